### design/tof_time_mass_converter_defines.svh
// assertion macros shared by the converter modules
`ifndef TOF_TIME_MASS_CONVERTER_DEFINES_SVH
`define TOF_TIME_MASS_CONVERTER_DEFINES_SVH
`ifndef SYNTH
`define TOFC_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tofc: same-cycle check failed");
`define TOFC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tofc: next-cycle check failed");
`else
`define TOFC_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define TOFC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### design/tofc_pkg.sv
package tofc_pkg;

   localparam int MaxTerms = 4;
   localparam int CoefW    = 64;
   localparam int TimeW    = 32;
   localparam int MassW    = 40;
   localparam int TermW    = 3;
   localparam int PAddrW   = 6;
   localparam int CsrDataW = 64;

   localparam logic [TermW-1:0] TermReset = 3'd2;

   localparam logic [2:0] RegTermCount = 3'd0;
   localparam logic [2:0] RegCoef0     = 3'd1;

   typedef struct packed {
      logic             operation;
      logic [TimeW-1:0] flight_time;
      logic [MassW-1:0] mass_value;
   } req_type;

   typedef struct packed {
      logic [MassW-1:0]        mass_out;
      logic signed [TimeW-1:0] time_out;
      logic                    error_flag;
   } rsp_type;

   typedef struct packed {
      logic [TermW-1:0]                  terms;
      logic [MaxTerms-1:0][CoefW-1:0]    coef;
   } cfg_type;

endpackage

### design/tofc_chan_if.sv
interface tofc_req_if;
   import tofc_pkg::*;
   logic             valid;
   logic             ready;
   logic             operation;
   logic [TimeW-1:0] flight_time;
   logic [MassW-1:0] mass_value;
   modport source (output valid, operation, flight_time, mass_value, input ready);
   modport sink (input valid, operation, flight_time, mass_value, output ready);
endinterface

interface tofc_rsp_if;
   import tofc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [MassW-1:0]        mass_out;
   logic signed [TimeW-1:0] time_out;
   logic                    error_flag;
   modport source (output valid, mass_out, time_out, error_flag, input ready);
   modport sink (input valid, mass_out, time_out, error_flag, output ready);
endinterface

### design/tof_time_mass_converter.sv
// time-of-flight time/mass converter
// req_ch carries one transaction per item: operation 0 turns flight_time
// (Q8.24 us) into mass_out (Q20.20), operation 1 turns mass_value into
// time_out (Q8.24, signed) using a linear solve and one secant refinement
// when more than two terms are in use. error_flag marks saturation, a zero
// divisor or too few terms.
// csr_* is an APB-style port with 64-bit registers at 8-byte spacing:
// term_count at 0x00, coefficient_0..3 at 0x08..0x20. pready is always high;
// write only while no transaction is in flight.
// one transaction is accepted every cycle while rsp is not held off. the
// pipeline depth comes from the 50-step square root, two 33-step dividers
// and two four-term polynomial evaluations, each step one stage.
// reset clears all stage valid bits, term_count to 2 and coefficients to 0.
// when rsp is held off with a result waiting, the whole pipeline freezes and
// req_ready drops; nothing is lost or repeated.
`include "tof_time_mass_converter_defines.svh"

module tof_time_mass_converter (
   input  logic                              clock,
   input  logic                              reset,
   tofc_req_if.sink                          req_ch,
   tofc_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tofc_pkg::PAddrW-1:0]       csr_paddr,
   input  logic [tofc_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [tofc_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                              csr_pready
);
   import tofc_pkg::*;

   logic [TermW-1:0]               term_count_ff;
   logic [TermW-1:0]               term_count_in;
   logic [MaxTerms-1:0][CoefW-1:0] coef_ff;
   logic [MaxTerms-1:0][CoefW-1:0] coef_in;
   logic                           csr_wr;
   logic [2:0]                     csr_idx;
   cfg_type                        cfg;
   req_type                        req_data;
   rsp_type                        rsp_data;
   logic                           pipe_en;
   logic                           pipe_out_valid;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[PAddrW-1:3];

   always_comb begin
      term_count_in = term_count_ff;
      coef_in       = coef_ff;
      if (csr_wr) begin
         if (csr_idx == RegTermCount) begin
            term_count_in = csr_pwdata[TermW-1:0];
         end
         for (int ci = 0; ci < MaxTerms; ci++) begin
            if (csr_idx == RegCoef0 + 3'(ci)) begin
               coef_in[ci] = csr_pwdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TermReset;
         coef_ff       <= '0;
      end else begin
         term_count_ff <= term_count_in;
         coef_ff       <= coef_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == RegTermCount) begin
         csr_prdata = {{(CsrDataW-TermW){1'b0}}, term_count_ff};
      end
      for (int ci = 0; ci < MaxTerms; ci++) begin
         if (csr_idx == RegCoef0 + 3'(ci)) begin
            csr_prdata = coef_ff[ci];
         end
      end
   end

   assign cfg.terms = term_count_ff;
   assign cfg.coef  = coef_ff;

   assign req_data.operation   = req_ch.operation;
   assign req_data.flight_time = req_ch.flight_time;
   assign req_data.mass_value  = req_ch.mass_value;

   assign pipe_en      = !pipe_out_valid || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   tofc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_ch.valid),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (pipe_out_valid),
      .out_data  (rsp_data)
   );

   assign rsp_ch.valid      = pipe_out_valid;
   assign rsp_ch.mass_out   = rsp_data.mass_out;
   assign rsp_ch.time_out   = rsp_data.time_out;
   assign rsp_ch.error_flag = rsp_data.error_flag;

   `TOFC_ASSERT_NEXT(a_terms_written, clock, reset, csr_wr && csr_idx == RegTermCount, term_count_ff == $past(csr_pwdata[2:0]))

endmodule

### design/tofc_pipe.sv
`include "tof_time_mass_converter_defines.svh"

module tofc_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tofc_pkg::req_type in_data,
   input  tofc_pkg::cfg_type cfg,
   output logic              out_valid,
   output tofc_pkg::rsp_type out_data
);
   import tofc_pkg::*;

   localparam int SqrtBits  = 50;
   localparam int QBits     = 33;
   localparam int HornerLen = 3 * MaxTerms;
   localparam int OffB1     = SqrtBits;
   localparam int OffB2     = OffB1 + 1;
   localparam int OffBD     = OffB2 + 1;
   localparam int OffBF     = OffBD + QBits;
   localparam int OffC0     = OffBF + 1;
   localparam int OffCH     = OffC0 + 1;
   localparam int OffCS     = OffCH + HornerLen;
   localparam int OffC2     = OffCS + 1;
   localparam int OffCD     = OffC2 + 1;
   localparam int OffCF     = OffCD + QBits;
   localparam int OffD0     = OffCF + 1;
   localparam int OffDH     = OffD0 + 1;
   localparam int OffQ1     = OffDH + HornerLen;
   localparam int OffQ2     = OffQ1 + 1;
   localparam int OffQ3     = OffQ2 + 1;
   localparam int OffQ4     = OffQ3 + 1;
   localparam int Depth     = OffQ4 + 1;

   localparam logic signed [32:0] HalfUs   = 33'sd8388608;
   localparam logic [63:0]        MagMax   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [MassW-1:0]   MassMax  = '1;
   localparam logic [32:0]        QLimit   = 33'h1_0000_0000;

   typedef struct packed {
      logic signed [32:0] t;
      logic signed [63:0] acc;
      logic [64:0]        pl;
      logic [64:0]        ph;
      logic               pneg;
      logic               psat;
      logic [61:0]        sqh;
      logic [62:0]        sqm;
      logic [63:0]        sql;
      logic               pos;
   } lane_type;

   typedef struct packed {
      logic               op;
      logic [TimeW-1:0]   ft;
      logic [MassW-1:0]   m;
      logic [TermW-1:0]   n;
      logic [52:0]        srem;
      logic [SqrtBits-1:0] root;
      logic signed [63:0] num;
      logic signed [63:0] den;
      logic [63:0]        nmag;
      logic [63:0]        dmag;
      logic               dneg;
      logic               dzero;
      logic               qsat;
      logic [63:0]        drem;
      logic [32:0]        q;
      logic               err;
      logic               sat;
      logic               sec;
      logic               chk;
      logic signed [31:0] t0;
      logic signed [31:0] tout;
      logic signed [31:0] te;
      logic signed [32:0] y1;
      lane_type           la;
      lane_type           lb;
      logic [MassW-1:0]   ma;
      logic [MassW-1:0]   mb;
      logic [MassW-1:0]   da;
      logic [MassW-1:0]   db;
      rsp_type            rsp;
   } item_type;

   function automatic logic ovf64(input logic signed [64:0] v);
      return v[64] != v[63];
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
      if (v[64] != v[63]) begin
         return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return v[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [35:0] v,
                                                   output logic s);
      s = 1'b0;
      if (v > 36'sd2147483647) begin
         s = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -36'sd2147483648) begin
         s = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic item_type load(input req_type rq, input cfg_type c);
      item_type s;
      s      = '0;
      s.op   = rq.operation;
      s.ft   = rq.flight_time;
      s.m    = rq.mass_value;
      s.n    = (c.terms > TermW'(MaxTerms)) ? TermW'(MaxTerms) : c.terms;
      return s;
   endfunction

   function automatic item_type sqrt_step(input item_type s, input int b);
      item_type   r;
      logic [99:0] rad;
      logic [52:0] rn;
      logic [52:0] tr;
      r   = s;
      rad = {s.m, 60'd0};
      rn  = {s.srem[50:0], rad[2*b +: 2]};
      tr  = {1'b0, s.root, 2'b01};
      if (rn >= tr) begin
         r.srem = rn - tr;
         r.root = {s.root[SqrtBits-2:0], 1'b1};
      end else begin
         r.srem = rn;
         r.root = {s.root[SqrtBits-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic item_type setup1(input item_type s, input cfg_type c);
      item_type           r;
      logic signed [64:0] d;
      logic [63:0]        c0;
      r     = s;
      c0    = c.coef[0];
      d     = {15'd0, s.root} - {c0[63], c0};
      r.num = sat64(d);
      r.den = $signed(c.coef[1]);
      r.sat = s.sat | (s.op & (s.n >= 3'd2) & ovf64(d));
      return r;
   endfunction

   function automatic item_type div_prep(input item_type s);
      item_type r;
      r       = s;
      r.nmag  = mag64(s.num);
      r.dmag  = mag64(s.den);
      r.dzero = (s.den == '0);
      r.dneg  = s.num[63] ^ s.den[63];
      r.qsat  = {9'd0, r.nmag[63:9]} >= r.dmag;
      r.drem  = {9'd0, r.nmag[63:9]};
      r.q     = '0;
      return r;
   endfunction

   function automatic item_type div_step(input item_type s, input int j);
      item_type    r;
      logic [87:0] nn;
      logic [64:0] rr;
      r  = s;
      nn = {s.nmag, 24'd0} >> j;
      rr = {s.drem, nn[0]};
      if (rr >= {1'b0, s.dmag}) begin
         rr   = rr - {1'b0, s.dmag};
         r.q  = {s.q[31:0], 1'b1};
      end else begin
         r.q  = {s.q[31:0], 1'b0};
      end
      r.drem = rr[63:0];
      return r;
   endfunction

   function automatic logic signed [34:0] div_result(input item_type s, output logic qs);
      logic [32:0] qv;
      qs = s.qsat || (s.q > QLimit);
      qv = qs ? QLimit : s.q;
      return s.dneg ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
   endfunction

   function automatic item_type fin1(input item_type s);
      item_type           r;
      logic signed [34:0] qr;
      logic signed [31:0] cv;
      logic               qs;
      logic               cs;
      r  = s;
      qr = div_result(s, qs);
      cv = clamp32({qr[34], qr}, cs);
      if (s.op) begin
         if ((s.n < 3'd2) || s.dzero) begin
            r.err  = 1'b1;
            r.t0   = '0;
            r.tout = '0;
            r.sec  = 1'b0;
         end else begin
            r.t0   = cv;
            r.tout = cv;
            r.sat  = s.sat | qs | cs;
            r.sec  = s.n > 3'd2;
         end
      end else begin
         r.sec = 1'b0;
      end
      return r;
   endfunction

   function automatic lane_type lane_start(input logic signed [32:0] t);
      lane_type l;
      l   = '0;
      l.t = t;
      return l;
   endfunction

   function automatic item_type sec_start(input item_type s);
      item_type r;
      r    = s;
      r.y1 = {s.t0[31], s.t0} - HalfUs;
      r.la = lane_start(r.y1);
      r.lb = lane_start({s.t0[31], s.t0} + HalfUs);
      return r;
   endfunction

   function automatic lane_type horner(input lane_type l, input int ph, input int ci,
                                       input logic [TermW-1:0] n, input cfg_type c);
      lane_type           r;
      logic [63:0]        am;
      logic [32:0]        tm;
      logic [97:0]        pr;
      logic [63:0]        mv;
      logic signed [64:0] sm;
      r = l;
      if (ph == 0) begin
         am     = mag64(l.acc);
         tm     = l.t[32] ? 33'(-l.t) : 33'(l.t);
         r.pl   = {33'd0, am[31:0]} * {32'd0, tm};
         r.ph   = {33'd0, am[63:32]} * {32'd0, tm};
         r.pneg = l.acc[63] ^ l.t[32];
      end else if (ph == 1) begin
         pr = {1'b0, l.ph, 32'd0} + {33'd0, l.pl} + 98'd8388608;
         if (|pr[97:87]) begin
            r.psat = 1'b1;
            mv     = MagMax;
         end else begin
            mv     = pr[87:24];
         end
         r.acc = l.pneg ? -$signed(mv) : $signed(mv);
      end else if (ci < int'(n)) begin
         sm     = {l.acc[63], l.acc} + {c.coef[ci][63], c.coef[ci]};
         r.acc  = sat64(sm);
         r.psat = l.psat | ovf64(sm);
      end
      return r;
   endfunction

   function automatic item_type sec_sub(input item_type s);
      item_type           r;
      logic signed [64:0] dd;
      logic signed [64:0] nd;
      r     = s;
      dd    = {s.lb.acc[63], s.lb.acc} - {s.la.acc[63], s.la.acc};
      nd    = {15'd0, s.root} - {s.la.acc[63], s.la.acc};
      r.den = sat64(dd);
      r.num = sat64(nd);
      r.sat = s.sat | (s.sec & (s.la.psat | s.lb.psat | ovf64(dd) | ovf64(nd)));
      return r;
   endfunction

   function automatic item_type fin2(input item_type s);
      item_type           r;
      logic signed [34:0] qr;
      logic signed [35:0] v;
      logic               qs;
      logic               cs;
      r  = s;
      qr = div_result(s, qs);
      v  = {{3{s.y1[32]}}, s.y1} + {qr[34], qr};
      r.te = clamp32(v, cs);
      r.chk = 1'b0;
      if (s.sec) begin
         if (s.dzero) begin
            r.err = 1'b1;
         end else begin
            r.sat = s.sat | qs | cs;
            r.chk = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic item_type mass_start(input item_type s);
      item_type r;
      r    = s;
      r.la = lane_start({s.te[31], s.te});
      r.lb = lane_start(s.op ? {s.t0[31], s.t0} : {1'b0, s.ft});
      return r;
   endfunction

   function automatic lane_type sq_mult(input lane_type l);
      lane_type    r;
      logic [30:0] sh;
      logic [31:0] sl;
      r     = l;
      sh    = l.acc[62:32];
      sl    = l.acc[31:0];
      r.pos = !l.acc[63] && (l.acc != '0);
      r.sqh = {31'd0, sh} * {31'd0, sh};
      r.sqm = {32'd0, sh} * {31'd0, sl};
      r.sql = {32'd0, sl} * {32'd0, sl};
      return r;
   endfunction

   function automatic logic [MassW-1:0] sq_round(input lane_type l, output logic ms);
      logic [126:0] p;
      p  = {1'b0, l.sqh, 64'd0} + {31'd0, l.sqm, 33'd0} + {63'd0, l.sql}
           + {67'd0, 1'b1, 59'd0};
      ms = l.pos && (|p[126:100]);
      if (!l.pos) begin
         return '0;
      end
      return ms ? MassMax : p[99:60];
   endfunction

   function automatic item_type mass_round(input item_type s);
      item_type r;
      logic     msa;
      logic     msb;
      r     = s;
      r.ma  = sq_round(s.la, msa);
      r.mb  = sq_round(s.lb, msb);
      r.sat = s.sat | (!s.op & (s.lb.psat | msb));
      return r;
   endfunction

   function automatic item_type mass_diff(input item_type s);
      item_type r;
      r    = s;
      r.da = (s.ma >= s.m) ? s.ma - s.m : s.m - s.ma;
      r.db = (s.mb >= s.m) ? s.mb - s.m : s.m - s.mb;
      return r;
   endfunction

   function automatic item_type finish(input item_type s);
      item_type r;
      r                = s;
      r.rsp.mass_out   = s.op ? '0 : s.mb;
      r.rsp.time_out   = !s.op ? '0 : ((s.chk && (s.da < s.db)) ? s.te : s.tout);
      r.rsp.error_flag = s.err | s.sat;
      return r;
   endfunction

   item_type         prv    [Depth];
   item_type         st_in  [Depth];
   item_type         st_ff  [Depth];
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;

   assign prv[0] = load(in_data, cfg);

   for (genvar gk = 1; gk < Depth; gk++) begin : g_link
      assign prv[gk] = st_ff[gk-1];
   end

   for (genvar gk = 0; gk < Depth; gk++) begin : g_stage
      if (gk < OffB1) begin : g_sqrt
         always_comb st_in[gk] = sqrt_step(prv[gk], SqrtBits - 1 - gk);
      end else if (gk == OffB1) begin : g_setup
         always_comb st_in[gk] = setup1(prv[gk], cfg);
      end else if (gk == OffB2 || gk == OffC2) begin : g_prep
         always_comb st_in[gk] = div_prep(prv[gk]);
      end else if (gk >= OffBD && gk < OffBF) begin : g_div1
         always_comb st_in[gk] = div_step(prv[gk], QBits - 1 - (gk - OffBD));
      end else if (gk == OffBF) begin : g_fin1
         always_comb st_in[gk] = fin1(prv[gk]);
      end else if (gk == OffC0) begin : g_sec
         always_comb st_in[gk] = sec_start(prv[gk]);
      end else if (gk >= OffCH && gk < OffCS) begin : g_poly1
         localparam int Ph = (gk - OffCH) % 3;
         localparam int Ci = MaxTerms - 1 - (gk - OffCH) / 3;
         always_comb begin
            st_in[gk]    = prv[gk];
            st_in[gk].la = horner(prv[gk].la, Ph, Ci, prv[gk].n, cfg);
            st_in[gk].lb = horner(prv[gk].lb, Ph, Ci, prv[gk].n, cfg);
         end
      end else if (gk == OffCS) begin : g_csub
         always_comb st_in[gk] = sec_sub(prv[gk]);
      end else if (gk >= OffCD && gk < OffCF) begin : g_div2
         always_comb st_in[gk] = div_step(prv[gk], QBits - 1 - (gk - OffCD));
      end else if (gk == OffCF) begin : g_fin2
         always_comb st_in[gk] = fin2(prv[gk]);
      end else if (gk == OffD0) begin : g_mass
         always_comb st_in[gk] = mass_start(prv[gk]);
      end else if (gk >= OffDH && gk < OffQ1) begin : g_poly2
         localparam int Ph = (gk - OffDH) % 3;
         localparam int Ci = MaxTerms - 1 - (gk - OffDH) / 3;
         always_comb begin
            st_in[gk]    = prv[gk];
            st_in[gk].la = horner(prv[gk].la, Ph, Ci, prv[gk].n, cfg);
            st_in[gk].lb = horner(prv[gk].lb, Ph, Ci, prv[gk].n, cfg);
         end
      end else if (gk == OffQ1) begin : g_sq
         always_comb begin
            st_in[gk]    = prv[gk];
            st_in[gk].la = sq_mult(prv[gk].la);
            st_in[gk].lb = sq_mult(prv[gk].lb);
         end
      end else if (gk == OffQ2) begin : g_round
         always_comb st_in[gk] = mass_round(prv[gk]);
      end else if (gk == OffQ3) begin : g_diff
         always_comb st_in[gk] = mass_diff(prv[gk]);
      end else begin : g_finish
         always_comb st_in[gk] = finish(prv[gk]);
      end
   end

   assign vld_in = {vld_ff[Depth-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Depth; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = vld_ff[Depth-1];
   assign out_data  = st_ff[Depth-1].rsp;

   `TOFC_ASSERT_IMPLIES(a_mass_op_no_time, clock, reset,
                        out_valid && !st_ff[Depth-1].op, out_data.time_out == '0)
   `TOFC_ASSERT_IMPLIES(a_time_op_no_mass, clock, reset,
                        out_valid && st_ff[Depth-1].op, out_data.mass_out == '0)
   `TOFC_ASSERT_IMPLIES(a_few_terms_error, clock, reset,
                        out_valid && st_ff[Depth-1].op && st_ff[Depth-1].n < 3'd2,
                        out_data.error_flag)

endmodule
